@@ rtl/gdas_pkg.sv @@
// ----------------------------------------------------------------------------
// gdas_pkg
// shared constants and calendar helpers for the gregorian date add/subtract core
// ----------------------------------------------------------------------------
package gdas_pkg;

    // usable width of the day count
    localparam int COUNT_BITS = 16;
    localparam int CNT_PORT_W = 16;
    localparam int N_W        = (COUNT_BITS < CNT_PORT_W) ? COUNT_BITS : CNT_PORT_W;
    // signed day accumulator: holds day + count, or day - count
    localparam int ACC_W      = COUNT_BITS + 2;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  FIX_YEAR   = 14'd1999;
    localparam logic [YEAR_W-1:0]  RESET_YEAR = 14'd1900;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
    localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

    // item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;
    localparam logic [1:0] KIND_CMP  = 2'd3;

    // divisibility by 25 via the modular inverse of 25 mod 2^14
    localparam logic [YEAR_W-1:0] INV25    = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = YEAR_W'(y * INV25);
        div25 = (prod <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0]  y,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
            4'd2:                                      d = is_leap(y) ? 5'd29 : 5'd28;
            default:                                   d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/gregorian_date_add_subtract_core.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_add_subtract_core
// holds a gregorian date and loads, compares or moves it by a day count
// ----------------------------------------------------------------------------
// The core keeps one date (reset value 1900-01-01). Each input item carries a
// kind on s_tuser: load, add days, subtract days or compare. Load takes the
// supplied date, or 1999-01-01 with load_fixed set if the date is invalid.
// Add and subtract walk the date one month per clock through a single shared
// month-length unit (month table plus leap-year test); results past 9999-12-31
// or before 0001-01-01 saturate and set range_error. Compare sets is_greater
// and is_equal against the supplied date. Every item returns one result item
// holding the date after the step and the flags. Load and compare pass from
// accept through the done state to the output register; add and subtract
// first step month by month, a full 65535-day move in about 2160 steps. The
// input is taken only while the sequencer is idle; a finished result may
// still wait on the output register while the next item is accepted.
module gregorian_date_add_subtract_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // date_year[13:0], date_month[17:14], date_day[22:18],
                                   // day_count[38:23], zero[39]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                                   // is_greater[23], is_equal[24], load_fixed[25],
                                   // range_error[26], zero[31:27]
);

    localparam int YW = gdas_pkg::YEAR_W;
    localparam int MW = gdas_pkg::MONTH_W;
    localparam int DW = gdas_pkg::DAY_W;
    localparam int AW = gdas_pkg::ACC_W;
    localparam int NW = gdas_pkg::N_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_SUB  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [YW-1:0]      year_reg, year_next;
    logic [MW-1:0]      month_reg, month_next;
    logic [DW-1:0]      day_reg, day_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic               gt_reg, gt_next;
    logic               eq_reg, eq_next;
    logic               fixed_reg, fixed_next;
    logic               rerr_reg, rerr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;

    // input fields
    logic [1:0]    in_kind;
    logic [YW-1:0] in_year;
    logic [MW-1:0] in_month;
    logic [DW-1:0] in_day;
    logic [NW-1:0] in_count;

    assign in_kind  = s_tuser;
    assign in_year  = s_tdata[13:0];
    assign in_month = s_tdata[17:14];
    assign in_day   = s_tdata[22:18];
    assign in_count = s_tdata[23 +: NW];

    // month stepping for subtract: the month we move back into
    logic [YW-1:0] prev_year;
    logic [MW-1:0] prev_month;
    assign prev_year  = (month_reg == gdas_pkg::JANUARY) ? (year_reg - 14'd1) : year_reg;
    assign prev_month = (month_reg == gdas_pkg::JANUARY) ? gdas_pkg::DECEMBER
                                                         : (month_reg - 4'd1);

    // shared month-length unit, operands picked by state
    logic [YW-1:0] dim_year;
    logic [MW-1:0] dim_month;
    logic [DW-1:0] dim;
    logic signed [AW-1:0] dim_ext;

    always_comb begin
        case (state_reg)
            ST_ADD: begin
                dim_year  = year_reg;
                dim_month = month_reg;
            end
            ST_SUB: begin
                dim_year  = prev_year;
                dim_month = prev_month;
            end
            default: begin
                dim_year  = in_year;
                dim_month = in_month;
            end
        endcase
    end

    assign dim     = gdas_pkg::days_in(dim_year, dim_month);
    assign dim_ext = $signed({{(AW-DW){1'b0}}, dim});

    // load validity
    logic load_ok;
    assign load_ok = (in_year >= gdas_pkg::YEAR_MIN) && (in_year <= gdas_pkg::YEAR_MAX) &&
                     (in_month >= gdas_pkg::JANUARY) && (in_month <= gdas_pkg::DECEMBER) &&
                     (in_day != 5'd0) && (in_day <= dim);

    logic signed [AW-1:0] day_ext, cnt_ext;
    assign day_ext = $signed({{(AW-DW){1'b0}}, day_reg});
    assign cnt_ext = $signed({{(AW-NW){1'b0}}, in_count});

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        acc_next      = acc_reg;
        gt_next       = gt_reg;
        eq_next       = eq_reg;
        fixed_next    = fixed_reg;
        rerr_next     = rerr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    gt_next    = 1'b0;
                    eq_next    = 1'b0;
                    fixed_next = 1'b0;
                    rerr_next  = 1'b0;
                    case (in_kind)
                        gdas_pkg::KIND_LOAD: begin
                            if (load_ok) begin
                                year_next  = in_year;
                                month_next = in_month;
                                day_next   = in_day;
                            end else begin
                                year_next  = gdas_pkg::FIX_YEAR;
                                month_next = gdas_pkg::JANUARY;
                                day_next   = gdas_pkg::FIRST_DAY;
                                fixed_next = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        gdas_pkg::KIND_ADD: begin
                            acc_next   = day_ext + cnt_ext;
                            state_next = ST_ADD;
                        end
                        gdas_pkg::KIND_SUB: begin
                            acc_next   = day_ext - cnt_ext;
                            state_next = ST_SUB;
                        end
                        default: begin
                            // compare, year first, then month, then day
                            if (year_reg != in_year) begin
                                gt_next = (year_reg > in_year);
                            end else if (month_reg != in_month) begin
                                gt_next = (month_reg > in_month);
                            end else begin
                                gt_next = (day_reg > in_day);
                            end
                            eq_next = (year_reg == in_year) && (month_reg == in_month) &&
                                      (day_reg == in_day);
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                if (acc_reg > dim_ext) begin
                    acc_next = acc_reg - dim_ext;
                    if (month_reg == gdas_pkg::DECEMBER) begin
                        if (year_reg >= gdas_pkg::YEAR_MAX) begin
                            // ran past the last representable date
                            year_next  = gdas_pkg::YEAR_MAX;
                            month_next = gdas_pkg::DECEMBER;
                            day_next   = gdas_pkg::LAST_DAY;
                            rerr_next  = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            year_next  = year_reg + 14'd1;
                            month_next = gdas_pkg::JANUARY;
                        end
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end else begin
                    day_next   = acc_reg[DW-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_SUB: begin
                if (acc_reg <= $signed({AW{1'b0}})) begin
                    if ((month_reg == gdas_pkg::JANUARY) && (year_reg <= gdas_pkg::YEAR_MIN)) begin
                        // ran past the first representable date
                        year_next  = gdas_pkg::YEAR_MIN;
                        month_next = gdas_pkg::JANUARY;
                        day_next   = gdas_pkg::FIRST_DAY;
                        rerr_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        year_next  = prev_year;
                        month_next = prev_month;
                        acc_next   = acc_reg + dim_ext;
                    end
                end else begin
                    day_next   = acc_reg[DW-1:0];
                    state_next = ST_DONE;
                end
            end
            default: begin
                // wait for the output register to free up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, rerr_reg, fixed_reg, eq_reg, gt_reg,
                                     day_reg, month_reg, year_reg};
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            year_reg     <= gdas_pkg::RESET_YEAR;
            month_reg    <= gdas_pkg::JANUARY;
            day_reg      <= gdas_pkg::FIRST_DAY;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and work registers, no reset needed
    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        gt_reg      <= gt_next;
        eq_reg      <= eq_next;
        fixed_reg   <= fixed_next;
        rerr_reg    <= rerr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // held month always stays legal
    a_month_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= gdas_pkg::JANUARY) && (month_reg <= gdas_pkg::DECEMBER))
        else $error("held month out of range");

    // held year always within the supported span
    a_year_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (year_reg >= gdas_pkg::YEAR_MIN) && (year_reg <= gdas_pkg::YEAR_MAX))
        else $error("held year out of range");

    // one item at a time: after an accept the input closes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input open right after accept");

    // a result never carries both load and range flags
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[25] && m_tdata[26]))
        else $error("load_fixed and range_error both set");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gregorian date add/subtract core
// ----------------------------------------------------------------------------
// Items go into the input stream with random gaps. A calendar predictor in the
// bench follows every accepted item and queues the result it should produce.
// A monitor compares each accepted result against the oldest queued one, field
// by field. Directed tests cover the reset date, invalid loads, leap days,
// saturation at both ends, zero counts and compare tie-breaks. A random phase
// then mixes well-formed loads with moves, compares and raw noise.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int LONG_HOLD       = 100;   // receiver hold-off for the pressure test
    localparam int DRAIN_CYCLES    = 20;    // settle time after the last result
    localparam int RANDOM_ITEMS    = 240;
    localparam int QUIET_TAIL      = 40;    // last random items run without idling

    // one result item as the core should return it
    typedef struct packed {
        logic [gdas_pkg::YEAR_W-1:0]  year;
        logic [gdas_pkg::MONTH_W-1:0] month;
        logic [gdas_pkg::DAY_W-1:0]   day;
        logic                         greater;
        logic                         equal;
        logic                         fixed;
        logic                         range_err;
    } date_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // date_year[13:0], date_month[17:14], date_day[22:18],
                             // day_count[38:23], zero[39]
    logic [1:0]  s_tuser;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // cur_year[13:0], cur_month[17:14], cur_day[22:18],
                             // is_greater[23], is_equal[24], load_fixed[25],
                             // range_error[26], zero[31:27]

    // predictor copy of the held date
    int cal_year;
    int cal_month;
    int cal_day;

    date_result_t pending_results[$];

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  range_errors_seen;
    int  fixes_seen;
    int  equals_seen;
    int  greaters_seen;
    bit  quiet;        // no idling on either side
    bit  hold_req;     // ask the receiver for one long hold-off
    bit  hold_taken;
    int  hold_left;
    int  stall_left;

    gregorian_date_add_subtract_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days in month, zero for a month outside 1..12
    function automatic int month_length(input int y, input int m);
        if (m < 1 || m > MONTHS_PER_YEAR)
            return 0;
        case (m)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // apply one item to the held date and return the result it produces
    function automatic date_result_t calendar_step(input logic [1:0] kind, input int y,
                                                   input int m, input int d, input int n);
        date_result_t r;
        int acc;
        r = '0;
        case (kind)
            gdas_pkg::KIND_LOAD: begin
                if (y < gdas_pkg::YEAR_MIN || y > gdas_pkg::YEAR_MAX ||
                    m < 1 || m > MONTHS_PER_YEAR ||
                    d < 1 || d > month_length(y, m)) begin
                    // invalid date falls back to the fixed default
                    cal_year  = gdas_pkg::FIX_YEAR;
                    cal_month = gdas_pkg::JANUARY;
                    cal_day   = gdas_pkg::FIRST_DAY;
                    r.fixed   = 1'b1;
                end else begin
                    cal_year  = y;
                    cal_month = m;
                    cal_day   = d;
                end
            end
            gdas_pkg::KIND_ADD: begin
                acc = cal_day + n;
                while (acc > month_length(cal_year, cal_month)) begin
                    acc -= month_length(cal_year, cal_month);
                    cal_month++;
                    if (cal_month > MONTHS_PER_YEAR) begin
                        cal_month = gdas_pkg::JANUARY;
                        cal_year++;
                        if (cal_year > gdas_pkg::YEAR_MAX) begin
                            // ran past the last representable day
                            cal_year    = gdas_pkg::YEAR_MAX;
                            cal_month   = gdas_pkg::DECEMBER;
                            acc         = gdas_pkg::LAST_DAY;
                            r.range_err = 1'b1;
                            break;
                        end
                    end
                end
                cal_day = acc;
            end
            gdas_pkg::KIND_SUB: begin
                acc = cal_day - n;
                while (acc <= 0) begin
                    cal_month--;
                    if (cal_month < 1) begin
                        cal_month = gdas_pkg::DECEMBER;
                        if (cal_year <= gdas_pkg::YEAR_MIN) begin
                            // ran before the first representable day
                            cal_year    = gdas_pkg::YEAR_MIN;
                            cal_month   = gdas_pkg::JANUARY;
                            acc         = gdas_pkg::FIRST_DAY;
                            r.range_err = 1'b1;
                            break;
                        end
                        cal_year--;
                    end
                    acc += month_length(cal_year, cal_month);
                end
                cal_day = acc;
            end
            default: begin
                // compare field by field: year, then month, then day
                if (cal_year != y)
                    r.greater = (cal_year > y);
                else if (cal_month != m)
                    r.greater = (cal_month > m);
                else
                    r.greater = (cal_day > d);
                r.equal = (cal_year == y) && (cal_month == m) && (cal_day == d);
            end
        endcase
        r.year  = cal_year[gdas_pkg::YEAR_W-1:0];
        r.month = cal_month[gdas_pkg::MONTH_W-1:0];
        r.day   = cal_day[gdas_pkg::DAY_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stream driving
    // ------------------------------------------------------------------------

    // offer one item and hold it until the core takes it
    task automatic send_item(input logic [1:0] kind,
                             input logic [gdas_pkg::YEAR_W-1:0] y,
                             input logic [gdas_pkg::MONTH_W-1:0] m,
                             input logic [gdas_pkg::DAY_W-1:0] d,
                             input logic [15:0] n);
        int n_used;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, n, d, m, y};
        do
            @(posedge aclk);
        while (!s_tready);
        // only the low N_W bits of the count take part
        n_used = int'(n) & ((1 << gdas_pkg::N_W) - 1);
        pending_results.push_back(calendar_step(kind, int'(y), int'(m), int'(d), n_used));
        items_sent++;
        // random gap before the next item
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
        end
    endtask

    // lower valid and wait for every queued result to come back
    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side: ready pattern and checking
    // ------------------------------------------------------------------------

    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at result %0d: %s expected %0d got %0d",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        date_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, data", 0, int'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[13:0] != want.year)
                    report_mismatch("cur_year", want.year, m_tdata[13:0]);
                if (m_tdata[17:14] != want.month)
                    report_mismatch("cur_month", want.month, m_tdata[17:14]);
                if (m_tdata[22:18] != want.day)
                    report_mismatch("cur_day", want.day, m_tdata[22:18]);
                if (m_tdata[23] != want.greater)
                    report_mismatch("is_greater", want.greater, m_tdata[23]);
                if (m_tdata[24] != want.equal)
                    report_mismatch("is_equal", want.equal, m_tdata[24]);
                if (m_tdata[25] != want.fixed)
                    report_mismatch("load_fixed", want.fixed, m_tdata[25]);
                if (m_tdata[26] != want.range_err)
                    report_mismatch("range_error", want.range_err, m_tdata[26]);
                range_errors_seen += want.range_err;
                fixes_seen        += want.fixed;
                equals_seen       += want.equal;
                greaters_seen     += want.greater;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // the date right after reset must equal 1900-01-01
    task automatic test_reset_date();
        send_item(gdas_pkg::KIND_CMP, 14'd1900, 4'd1, 5'd1, 16'd0);
    endtask

    // valid loads, every kind of invalid load, and the all-ones fields
    task automatic test_loads();
        send_item(gdas_pkg::KIND_LOAD, 14'd2000, 4'd2, 5'd29, 16'd0);     // leap day, 400 rule
        send_item(gdas_pkg::KIND_LOAD, 14'd1900, 4'd2, 5'd29, 16'd0);     // no leap day, 100 rule
        send_item(gdas_pkg::KIND_LOAD, 14'd0, 4'd6, 5'd10, 16'd0);        // year zero
        send_item(gdas_pkg::KIND_LOAD, 14'h3FFF, 4'hF, 5'h1F, 16'hFFFF);  // every field at top
        send_item(gdas_pkg::KIND_LOAD, 14'd2021, 4'd0, 5'd5, 16'd0);      // month zero
        send_item(gdas_pkg::KIND_LOAD, 14'd2021, 4'd7, 5'd0, 16'd0);      // day zero
        send_item(gdas_pkg::KIND_LOAD, 14'd2023, 4'd4, 5'd31, 16'd0);     // day past month end
        send_item(gdas_pkg::KIND_LOAD, 14'd1999, 4'd8, 5'd31, 16'd0);     // august has 31 days
    endtask

    // moves across month and year ends, zero counts and both saturations
    task automatic test_moves();
        send_item(gdas_pkg::KIND_LOAD, 14'd2024, 4'd1, 5'd31, 16'd0);
        send_item(gdas_pkg::KIND_ADD, 14'd0, 4'd0, 5'd0, 16'd29);         // lands on a leap day
        send_item(gdas_pkg::KIND_ADD, 14'd0, 4'd0, 5'd0, 16'd0);          // zero count
        send_item(gdas_pkg::KIND_SUB, 14'd0, 4'd0, 5'd0, 16'd0);
        send_item(gdas_pkg::KIND_ADD, 14'd0, 4'd0, 5'd0, 16'hFFFF);       // largest forward move
        send_item(gdas_pkg::KIND_SUB, 14'd0, 4'd0, 5'd0, 16'hFFFF);       // and back again
        send_item(gdas_pkg::KIND_LOAD, 14'd9999, 4'd12, 5'd31, 16'd0);
        send_item(gdas_pkg::KIND_ADD, 14'd0, 4'd0, 5'd0, 16'd1);          // overflow saturates
        send_item(gdas_pkg::KIND_LOAD, 14'd1, 4'd1, 5'd1, 16'd0);
        send_item(gdas_pkg::KIND_SUB, 14'd0, 4'd0, 5'd0, 16'd1);          // underflow saturates
    endtask

    // greater and equal against later, earlier, tied and invalid dates
    task automatic test_compares();
        send_item(gdas_pkg::KIND_LOAD, 14'd2024, 4'd3, 5'd15, 16'd0);
        send_item(gdas_pkg::KIND_CMP, 14'd2024, 4'd3, 5'd14, 16'd0);      // tie down to the day
        send_item(gdas_pkg::KIND_CMP, 14'd2024, 4'd3, 5'd15, 16'd0);      // equal
        send_item(gdas_pkg::KIND_CMP, 14'd2025, 4'd1, 5'd1, 16'd0);       // supplied date later
        send_item(gdas_pkg::KIND_CMP, 14'd2024, 4'd2, 5'd20, 16'd0);      // greater on month
        send_item(gdas_pkg::KIND_CMP, 14'd2024, 4'd15, 5'd0, 16'd0);      // invalid date as given
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int i;
        quiet    = 1'b1;
        hold_req = 1'b1;
        send_item(gdas_pkg::KIND_LOAD, 14'd2010, 4'd5, 5'd20, 16'd0);
        for (i = 0; i < 9; i++)
            send_item(i % 2 ? gdas_pkg::KIND_SUB : gdas_pkg::KIND_ADD, 14'd0, 4'd0, 5'd0,
                      16'($urandom_range(0, 90)));
        wait_results_done();
        quiet = 1'b0;
    endtask

    // mostly well-formed loads followed by moves and compares, some noise
    task automatic test_random();
        int i;
        int sel;
        int y;
        int m;
        int d;
        int n;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
            sel = $urandom_range(0, 99);
            // day count: mostly short, sometimes long, a few over the full width
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 16'hFFFF);
                1, 2:    n = $urandom_range(0, 5000);
                default: n = $urandom_range(0, 400);
            endcase
            if (sel < 20) begin
                // valid load, sometimes close to either end of the year range
                case ($urandom_range(0, 5))
                    0:       y = $urandom_range(1, 3);
                    1:       y = $urandom_range(9995, 9999);
                    default: y = $urandom_range(1, 9999);
                endcase
                m = $urandom_range(1, 12);
                d = $urandom_range(1, month_length(y, m));
                send_item(gdas_pkg::KIND_LOAD, 14'(y), 4'(m), 5'(d), 16'(n));
            end else if (sel < 27) begin
                // raw load over the whole field ranges
                send_item(gdas_pkg::KIND_LOAD, 14'($urandom), 4'($urandom), 5'($urandom),
                          16'($urandom));
            end else if (sel < 55) begin
                send_item(gdas_pkg::KIND_ADD, 14'($urandom), 4'($urandom), 5'($urandom),
                          16'(n));
            end else if (sel < 83) begin
                send_item(gdas_pkg::KIND_SUB, 14'($urandom), 4'($urandom), 5'($urandom),
                          16'(n));
            end else if (sel < 92) begin
                // compare near the held date so that ties and equality show up
                y = cal_year;
                m = cal_month;
                d = cal_day;
                case ($urandom_range(0, 3))
                    0: d = d + $urandom_range(0, 2) - 1;
                    1: m = m + $urandom_range(0, 2) - 1;
                    2: y = y + $urandom_range(0, 2) - 1;
                    default: ;
                endcase
                send_item(gdas_pkg::KIND_CMP, 14'(y), 4'(m), 5'(d), 16'(n));
            end else begin
                send_item(gdas_pkg::KIND_CMP, 14'($urandom), 4'($urandom), 5'($urandom),
                          16'(n));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------

    initial begin
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = gdas_pkg::KIND_LOAD;
        m_tready          = 1'b0;
        cal_year          = gdas_pkg::RESET_YEAR;
        cal_month         = gdas_pkg::JANUARY;
        cal_day           = gdas_pkg::FIRST_DAY;
        mismatches        = 0;
        items_sent        = 0;
        results_seen      = 0;
        range_errors_seen = 0;
        fixes_seen        = 0;
        equals_seen       = 0;
        greaters_seen     = 0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        hold_taken        = 1'b0;
        hold_left         = 0;
        stall_left        = 0;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_date();
        test_loads();
        test_moves();
        test_compares();
        test_backpressure();
        test_random();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items and %0d results: loads, moves, compares, stalls",
                 items_sent, results_seen);
        $display("saw %0d saturations, %0d fixed loads, %0d equal and %0d greater compares",
                 range_errors_seen, fixes_seen, equals_seen, greaters_seen);
        if (mismatches == 0)
            $display("PASS gregorian_date_add_subtract_core");
        else
            $display("FAIL gregorian_date_add_subtract_core");
        $finish;
    end

    // watchdog: far beyond a run where every item takes the longest move
    initial begin
        #(30_000_000);
        $display("timeout with %0d results still pending", pending_results.size());
        $display("FAIL gregorian_date_add_subtract_core");
        $finish;
    end

endmodule
